>>> hdl/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

   localparam int TIME_BITS  = 32;
   localparam int RING_COUNT = 5;
   localparam int SEG_COUNT  = 6;
   localparam int GROUPS     = 4;

   localparam logic [2:0] BOUNCE_SEG   = 3'd5;
   localparam logic [7:0] BOUNCE_INDEX = 8'd254;
   localparam logic [5:0] BOUNCE_TOP   = 6'd60;
   localparam logic [5:0] BOUNCE_STEP  = 6'd4;

   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_SPEED  = 2'd1;

   localparam logic ACT_TICK    = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   typedef struct packed {
      logic       restart;
      logic       start_tick;
      logic       eval;
      logic [1:0] grp;
      logic       emit;
      logic [2:0] seg;
      logic [2:0] k;
      logic       last_k;
      logic       final_write;
   } cmd_type;

   typedef struct packed {
      logic       enabled;
      logic [3:0] due;
      logic       slot_free;
   } status_type;

   function automatic logic [7:0] base_period(input logic [1:0] g);
      case (g)
         2'd0:    base_period = 8'(1000 / 5);
         2'd1:    base_period = 8'(1000 / 7);
         2'd2:    base_period = 8'(1000 / 10);
         default: base_period = 8'(1000 / 30);
      endcase
   endfunction

   function automatic logic [7:0] ring_base(input logic [2:0] s);
      case (s)
         3'd0:    ring_base = 8'd229;
         3'd1:    ring_base = 8'd248;
         3'd2:    ring_base = 8'd238;
         3'd3:    ring_base = 8'd243;
         3'd4:    ring_base = 8'd233;
         default: ring_base = BOUNCE_INDEX;
      endcase
   endfunction

   function automatic logic [4:0] ring_start(input logic [2:0] s);
      case (s)
         3'd0:    ring_start = 5'd0;
         3'd1:    ring_start = 5'd4;
         3'd2:    ring_start = 5'd10;
         3'd3:    ring_start = 5'd15;
         3'd4:    ring_start = 5'd20;
         default: ring_start = 5'd0;
      endcase
   endfunction

   // bounce segment is a single write
   function automatic logic [2:0] ring_len(input logic [2:0] s);
      case (s)
         3'd0:    ring_len = 3'd4;
         3'd1:    ring_len = 3'd6;
         3'd2:    ring_len = 3'd5;
         3'd3:    ring_len = 3'd5;
         3'd4:    ring_len = 3'd5;
         default: ring_len = 3'd1;
      endcase
   endfunction

   // {red, green, blue}, six bits each
   function automatic logic [17:0] color_rom(input logic [4:0] i);
      case (i)
         5'd0:    color_rom = {6'd0,  6'd27, 6'd0};
         5'd1:    color_rom = {6'd2,  6'd28, 6'd1};
         5'd2:    color_rom = {6'd6,  6'd30, 6'd3};
         5'd3:    color_rom = {6'd10, 6'd32, 6'd6};
         5'd4:    color_rom = {6'd20, 6'd15, 6'd10};
         5'd5:    color_rom = {6'd18, 6'd14, 6'd10};
         5'd6:    color_rom = {6'd16, 6'd13, 6'd9};
         5'd7:    color_rom = {6'd15, 6'd12, 6'd9};
         5'd8:    color_rom = {6'd13, 6'd11, 6'd8};
         5'd9:    color_rom = {6'd12, 6'd10, 6'd8};
         5'd10:   color_rom = {6'd63, 6'd0,  6'd0};
         5'd11:   color_rom = {6'd53, 6'd0,  6'd0};
         5'd12:   color_rom = {6'd36, 6'd10, 6'd2};
         5'd13:   color_rom = {6'd63, 6'd29, 6'd0};
         5'd14:   color_rom = {6'd63, 6'd14, 6'd0};
         5'd15:   color_rom = {6'd17, 6'd0,  6'd0};
         5'd16:   color_rom = {6'd30, 6'd0,  6'd0};
         5'd17:   color_rom = {6'd44, 6'd0,  6'd0};
         5'd18:   color_rom = {6'd30, 6'd0,  6'd0};
         5'd19:   color_rom = {6'd17, 6'd0,  6'd0};
         5'd20:   color_rom = {6'd26, 6'd26, 6'd27};
         5'd21:   color_rom = {6'd24, 6'd25, 6'd31};
         5'd22:   color_rom = {6'd21, 6'd26, 6'd35};
         5'd23:   color_rom = {6'd0,  6'd36, 6'd40};
         5'd24:   color_rom = {6'd26, 6'd46, 6'd63};
         default: color_rom = 18'd0;
      endcase
   endfunction

endpackage

>>> hdl/palette_color_cycler.sv
`timescale 1ns / 1ps
// channel  ports                                             direction
// req      req_valid req_ready req_action req_now_ms         in
// rsp      rsp_valid rsp_ready rsp_palette_index rsp_red_level
//          rsp_green_level rsp_blue_level rsp_final_write    out
// csr      csr_we csr_index csr_wdata                        in, write only
//
// A tick is accepted, then the four group timers are checked one group at a time,
// then the write sequencer emits each write or skips a segment that is not due.
// Restart and disabled ticks are handled at accept and leave the block idle.
// Reset is synchronous: clears timers, ring offsets, bounce level, enable and rsp_valid; sets speed to 1.
// rsp_ready low with a beat waiting holds the sequencer; one output register holds a waiting beat.

module palette_color_cycler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_palette_index,
   output logic [5:0]  rsp_red_level,
   output logic [5:0]  rsp_green_level,
   output logic [5:0]  rsp_blue_level,
   output logic        rsp_final_write,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   pcc_pkg::cmd_type    cmd;
   pcc_pkg::status_type status;

   pcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   pcc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_now_ms        (req_now_ms),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_palette_index (rsp_palette_index),
      .rsp_red_level     (rsp_red_level),
      .rsp_green_level   (rsp_green_level),
      .rsp_blue_level    (rsp_blue_level),
      .rsp_final_write   (rsp_final_write)
   );

endmodule

>>> hdl/pcc_ctrl.sv
`timescale 1ns / 1ps

module pcc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_ready,
   input  pcc_pkg::status_type status,
   output pcc_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] grp_ff, grp_in;
   logic [2:0] seg_ff, seg_in;
   logic [2:0] k_ff, k_in;

   logic [pcc_pkg::SEG_COUNT-1:0] seg_en;
   logic                          later_en;
   logic                          last_k;
   logic                          accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign seg_en = {status.due[3], status.due[2], status.due[1],
                    status.due[0], status.due[0], status.due[0]};
   assign last_k = (k_ff == 3'(pcc_pkg::ring_len(seg_ff) - 3'd1));

   always_comb begin
      later_en = 1'b0;
      for (int i = 0; i < pcc_pkg::SEG_COUNT; i++) begin
         if ((3'(i) > seg_ff) && seg_en[i]) begin
            later_en = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      grp_in   = grp_ff;
      seg_in   = seg_ff;
      k_in     = k_ff;

      cmd             = '0;
      cmd.grp         = grp_ff;
      cmd.seg         = seg_ff;
      cmd.k           = k_ff;
      cmd.last_k      = last_k;
      cmd.final_write = last_k && !later_en;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == pcc_pkg::ACT_RESTART) begin
                  cmd.restart = 1'b1;
               end else if (status.enabled) begin
                  cmd.start_tick = 1'b1;
                  grp_in         = 2'd0;
                  state_in       = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            grp_in   = 2'(grp_ff + 2'd1);
            if (grp_ff == 2'(pcc_pkg::GROUPS - 1)) begin
               seg_in   = 3'd0;
               k_in     = 3'd0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!seg_en[seg_ff]) begin
               seg_in = 3'(seg_ff + 3'd1);
               if (seg_ff == pcc_pkg::BOUNCE_SEG) begin
                  state_in = ST_IDLE;
               end
            end else if (status.slot_free) begin
               cmd.emit = 1'b1;
               if (last_k) begin
                  k_in   = 3'd0;
                  seg_in = 3'(seg_ff + 3'd1);
                  if (seg_ff == pcc_pkg::BOUNCE_SEG) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  k_in = 3'(k_ff + 3'd1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         grp_ff   <= 2'd0;
         seg_ff   <= 3'd0;
         k_ff     <= 3'd0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         seg_ff   <= seg_in;
         k_ff     <= k_in;
      end
   end

endmodule

>>> hdl/pcc_datapath.sv
`timescale 1ns / 1ps

module pcc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   input  logic [31:0]         req_now_ms,
   input  pcc_pkg::cmd_type    cmd,
   output pcc_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_palette_index,
   output logic [5:0]          rsp_red_level,
   output logic [5:0]          rsp_green_level,
   output logic [5:0]          rsp_blue_level,
   output logic                rsp_final_write
);

   logic                          enabled_ff;
   logic [7:0]                    speed_ff;
   logic [7:0]                    tick_speed_ff;
   logic [pcc_pkg::TIME_BITS-1:0] now_ff;
   logic [pcc_pkg::TIME_BITS-1:0] stamps_ff [pcc_pkg::GROUPS];
   logic [3:0]                    due_ff;
   logic [2:0]                    offsets_ff [pcc_pkg::RING_COUNT];
   logic [5:0]                    level_ff, level_in;
   logic                          rising_ff, rising_in;

   logic                          rsp_valid_ff;
   logic [7:0]                    index_ff, index_in;
   logic [17:0]                   color_ff, color_in;
   logic                          final_ff;

   logic [15:0]                   period;
   logic [pcc_pkg::TIME_BITS-1:0] elapsed;
   logic                          fire;

   logic [2:0] len;
   logic [2:0] off_sel;
   logic [2:0] start;
   logic [3:0] sum;
   logic [2:0] entry;
   logic [2:0] off_next;
   logic       is_bounce;

   assign status.enabled   = enabled_ff;
   assign status.due       = due_ff;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   // group timer compare
   assign period  = 16'(pcc_pkg::base_period(cmd.grp)) * 16'(tick_speed_ff);
   assign elapsed = pcc_pkg::TIME_BITS'(now_ff - stamps_ff[cmd.grp]);
   assign fire    = (elapsed >= pcc_pkg::TIME_BITS'(period));

   // ring entry select
   assign is_bounce = (cmd.seg == pcc_pkg::BOUNCE_SEG);
   assign len       = pcc_pkg::ring_len(cmd.seg);
   assign off_sel   = is_bounce ? 3'd0 : offsets_ff[cmd.seg];
   assign start     = (off_sel >= len) ? 3'd0 : off_sel;
   assign sum       = {1'b0, start} + {1'b0, cmd.k};
   assign entry     = (sum >= {1'b0, len}) ? 3'(sum - {1'b0, len}) : sum[2:0];
   assign off_next  = (start == 3'd0) ? 3'(len - 3'd1) : 3'(start - 3'd1);

   always_comb begin
      rising_in = rising_ff;
      if (level_ff == 6'd0 || level_ff == pcc_pkg::BOUNCE_TOP) begin
         rising_in = !rising_ff;
      end
      level_in = rising_in ? 6'(level_ff + pcc_pkg::BOUNCE_STEP)
                           : 6'(level_ff - pcc_pkg::BOUNCE_STEP);
   end

   always_comb begin
      if (is_bounce) begin
         index_in = pcc_pkg::BOUNCE_INDEX;
         color_in = {level_in, 6'd0, 6'd0};
      end else begin
         index_in = 8'(pcc_pkg::ring_base(cmd.seg) + {5'd0, cmd.k});
         color_in = pcc_pkg::color_rom(5'(pcc_pkg::ring_start(cmd.seg) + {2'd0, entry}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         speed_ff   <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            pcc_pkg::CSR_ENABLE: enabled_ff <= csr_wdata[0];
            pcc_pkg::CSR_SPEED:  speed_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_tick) begin
         now_ff        <= pcc_pkg::TIME_BITS'(req_now_ms);
         tick_speed_ff <= speed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pcc_pkg::GROUPS; i++) begin
            stamps_ff[i] <= '0;
         end
         due_ff <= 4'd0;
      end else if (cmd.restart) begin
         for (int i = 0; i < pcc_pkg::GROUPS; i++) begin
            stamps_ff[i] <= '0;
         end
      end else if (cmd.start_tick) begin
         due_ff <= 4'd0;
      end else if (cmd.eval && fire) begin
         due_ff[cmd.grp]    <= 1'b1;
         stamps_ff[cmd.grp] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pcc_pkg::RING_COUNT; i++) begin
            offsets_ff[i] <= 3'd0;
         end
         level_ff  <= 6'd0;
         rising_ff <= 1'b0;
      end else if (cmd.emit) begin
         if (is_bounce) begin
            level_ff  <= level_in;
            rising_ff <= rising_in;
         end else if (cmd.last_k) begin
            offsets_ff[cmd.seg] <= off_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         index_ff <= index_in;
         color_ff <= color_in;
         final_ff <= cmd.final_write;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = index_ff;
   assign rsp_red_level     = color_ff[17:12];
   assign rsp_green_level   = color_ff[11:6];
   assign rsp_blue_level    = color_ff[5:0];
   assign rsp_final_write   = final_ff;

endmodule

>>> hdl/pcc_checker.sv
`timescale 1ns / 1ps

module pcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_palette_index,
   input logic [5:0] rsp_red_level,
   input logic [5:0] rsp_green_level,
   input logic [5:0] rsp_blue_level,
   input logic       rsp_final_write
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_palette_index)
         && $stable(rsp_red_level) && $stable(rsp_final_write))
      else $error("rsp beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_palette_index >= 8'd229 && rsp_palette_index <= 8'd254)
      else $error("palette index out of range");

   a_bounce_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_palette_index == 8'd254 |-> rsp_final_write
         && rsp_green_level == 6'd0 && rsp_blue_level == 6'd0
         && rsp_red_level[1:0] == 2'd0)
      else $error("bad bounce beat");

   a_busy_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_write |-> !req_ready)
      else $error("req taken while a tick is still emitting");

endmodule

bind palette_color_cycler pcc_checker u_pcc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_palette_index (rsp_palette_index),
   .rsp_red_level     (rsp_red_level),
   .rsp_green_level   (rsp_green_level),
   .rsp_blue_level    (rsp_blue_level),
   .rsp_final_write   (rsp_final_write)
);
